// ----- design/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg: shared definitions for the substring match block
// Sizes, register indexes and the window slot and result types that are used
// by the window cells and by the top level.
// ----------------------------------------------------------------------------
package smc_pkg;

    // Longest pattern in bytes, and the width of the row and column counters.
    localparam int MAX_PATTERN  = 8;
    localparam int COUNTER_BITS = 24;

    // Field and register widths.
    localparam int TEXT_W   = 8;
    localparam int FILE_W   = 16;
    localparam int LEN_W    = 4;
    localparam int PAT_W    = TEXT_W * MAX_PATTERN;
    localparam int CFG_W    = PAT_W;
    localparam int CELLS    = MAX_PATTERN - 1;
    localparam int IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Line feed ends a row.
    localparam logic [TEXT_W-1:0] NEWLINE = 8'h0A;

    // Saturation value of the row and column counters.
    localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PATTERN = 1'b0,
        CFG_LENGTH  = 1'b1
    } cfg_index_t;

    // One window slot: a text byte with its position and an in-file flag.
    typedef struct packed {
        logic                    valid;
        logic [TEXT_W-1:0]       data;
        logic [COUNTER_BITS-1:0] row;
        logic [COUNTER_BITS-1:0] col;
    } smc_slot_t;

    // Control common to all cells of the window.
    typedef struct packed {
        logic shift;
        logic flush;
    } smc_ctl_t;

    // One reported match.
    typedef struct packed {
        logic [FILE_W-1:0]       file;
        logic [COUNTER_BITS-1:0] row;
        logic [COUNTER_BITS-1:0] col;
    } smc_result_t;

endpackage

// ----- design/smc_cell.sv -----
// ----------------------------------------------------------------------------
// smc_cell: one stage of the text window
// Holds one earlier byte with its row and column, hands it to the next cell
// on every accepted word and compares it against its share of the pattern.
// ----------------------------------------------------------------------------
module smc_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smc_pkg::smc_ctl_t           ctl,
    input  smc_pkg::smc_slot_t          slot_in,
    input  logic [smc_pkg::TEXT_W-1:0]  pat_byte,
    input  logic                        check_en,
    output smc_pkg::smc_slot_t          slot_out,
    output logic                        match_ok
);

    logic                    valid_reg;
    logic                    valid_next;
    smc_pkg::smc_slot_t      slot_reg;

    // The in-file flag is cleared at the end of a file, after the check.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            valid_next = slot_in.valid && !ctl.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte and position move along with each accepted word.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            slot_reg <= slot_in;
        end
    end

    always_comb
    begin
        slot_out       = slot_reg;
        slot_out.valid = valid_reg;
    end

    // A lane outside the pattern always agrees.
    assign match_ok = !check_en || (valid_reg && (slot_reg.data == pat_byte));

endmodule

// ----- design/substring_match_row_column.sv -----
// ----------------------------------------------------------------------------
// substring_match_row_column: pattern search with row and column report
// Finds the leftmost non-overlapping occurrences of a 1 to 8 byte pattern in
// a stream of files and reports file number, row and column of each match.
// ----------------------------------------------------------------------------
// Usage:
//   Text arrives one byte per word on the input channel (in_valid/in_stall),
//   end_of_file marking the last byte of a file. Each match leaves on the
//   output channel (out_valid/out_stall) as one word holding file_number,
//   match_row and match_column of the match's first byte.
//   The pattern and its length are written through cfg_write/cfg_index/
//   cfg_data while the block is idle.
//   Throughput is one byte per cycle while in_stall is low: the byte window
//   is a row of cells that shift on every accepted word and compare in parallel.
//   A match is registered when its last byte is accepted.
//   The output register is backed by a one-word skid buffer, so input keeps
//   flowing while one result waits; in_stall rises only when both hold a
//   result, that is after the receiver has stalled with a second match
//   behind the first.
//   Reset empties the window, sets the row and column counters to one, clears
//   the file number and both output words; the pattern resets to zero and the length to one.
// ----------------------------------------------------------------------------
module substring_match_row_column (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration
    input  logic                               cfg_write,
    input  logic [0:0]                         cfg_index,
    input  logic [smc_pkg::CFG_W-1:0]          cfg_data,
    // Text input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [smc_pkg::TEXT_W-1:0]         text_byte,
    input  logic                               end_of_file,
    // Match output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [smc_pkg::FILE_W-1:0]         file_number,
    output logic [smc_pkg::COUNTER_BITS-1:0]   match_row,
    output logic [smc_pkg::COUNTER_BITS-1:0]   match_column
);

    // Configuration registers.
    logic [smc_pkg::PAT_W-1:0]        pattern_reg;
    logic [smc_pkg::LEN_W-1:0]        length_reg;

    // Position and scan state.
    logic [smc_pkg::COUNTER_BITS-1:0] row_reg;
    logic [smc_pkg::COUNTER_BITS-1:0] row_next;
    logic [smc_pkg::COUNTER_BITS-1:0] col_reg;
    logic [smc_pkg::COUNTER_BITS-1:0] col_next;
    logic [smc_pkg::IDX_W-1:0]        suppress_reg;
    logic [smc_pkg::IDX_W-1:0]        suppress_next;
    logic [smc_pkg::FILE_W-1:0]       file_reg;
    logic [smc_pkg::FILE_W-1:0]       file_next;

    // Window and compare.
    logic [smc_pkg::LEN_W-1:0]        eff_len;
    logic [smc_pkg::IDX_W-1:0]        len_m1;
    smc_pkg::smc_ctl_t                ctl;
    smc_pkg::smc_slot_t               win [smc_pkg::MAX_PATTERN];
    logic [smc_pkg::TEXT_W-1:0]       pat_sel [smc_pkg::MAX_PATTERN];
    logic [smc_pkg::MAX_PATTERN-1:0]  lane_en;
    logic [smc_pkg::MAX_PATTERN-1:0]  lane_ok;
    logic                             raw_hit;
    logic                             hit;
    logic                             in_accept;
    smc_pkg::smc_slot_t               first_slot;
    smc_pkg::smc_result_t             new_result;

    // Output register and skid buffer.
    logic                             out_valid_reg;
    logic                             out_valid_next;
    smc_pkg::smc_result_t             out_reg;
    smc_pkg::smc_result_t             out_next;
    logic                             skid_valid_reg;
    logic                             skid_valid_next;
    smc_pkg::smc_result_t             skid_reg;
    smc_pkg::smc_result_t             skid_next;
    logic                             push;
    logic                             pop;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= smc_pkg::LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (smc_pkg::cfg_index_t'(cfg_index))
                smc_pkg::CFG_PATTERN: pattern_reg <= cfg_data;
                smc_pkg::CFG_LENGTH:  length_reg  <= cfg_data[smc_pkg::LEN_W-1:0];
                default:              pattern_reg <= pattern_reg;
            endcase
        end
    end

    // Effective pattern length: zero counts as one, long values clamp.
    always_comb
    begin
        priority if (length_reg == '0)
        begin
            eff_len = smc_pkg::LEN_W'(1);
        end
        else if (length_reg > smc_pkg::LEN_W'(smc_pkg::MAX_PATTERN))
        begin
            eff_len = smc_pkg::LEN_W'(smc_pkg::MAX_PATTERN);
        end
        else
        begin
            eff_len = length_reg;
        end
    end

    assign len_m1 = smc_pkg::IDX_W'(eff_len - smc_pkg::LEN_W'(1));

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    assign ctl.shift = in_accept;
    assign ctl.flush = end_of_file;

    // The incoming byte is the newest window slot.
    always_comb
    begin
        first_slot.valid = 1'b1;
        first_slot.data  = text_byte;
        first_slot.row   = row_reg;
        first_slot.col   = col_reg;
    end

    assign win[0] = first_slot;

    // Window lane j holds pattern byte len-1-j.
    always_comb
    begin
        for (int j = 0; j < smc_pkg::MAX_PATTERN; j++)
        begin
            lane_en[j] = (smc_pkg::IDX_W'(j) <= len_m1);
            pat_sel[j] = pattern_reg[(len_m1 - smc_pkg::IDX_W'(j)) * smc_pkg::TEXT_W
                                     +: smc_pkg::TEXT_W];
        end
    end

    assign lane_ok[0] = (text_byte == pat_sel[0]);

    // Row of window cells, oldest byte at the far end.
    for (genvar c = 0; c < smc_pkg::CELLS; c++)
    begin : g_cell
        smc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .slot_in  (win[c]),
            .pat_byte (pat_sel[c+1]),
            .check_en (lane_en[c+1]),
            .slot_out (win[c+1]),
            .match_ok (lane_ok[c+1])
        );
    end

    assign raw_hit = &lane_ok;
    assign hit     = raw_hit && (suppress_reg == '0);

    // The match starts at the oldest slot that the pattern covers.
    always_comb
    begin
        new_result.file = file_reg;
        new_result.row  = win[len_m1].row;
        new_result.col  = win[len_m1].col;
    end

    // Position, suppression and file number for the next byte.
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        suppress_next = suppress_reg;
        file_next     = file_reg;
        if (in_accept)
        begin
            if (text_byte == smc_pkg::NEWLINE)
            begin
                row_next = (row_reg == smc_pkg::COUNTER_MAX) ? row_reg : row_reg + 1'b1;
                col_next = smc_pkg::COUNTER_BITS'(1);
            end
            else
            begin
                col_next = (col_reg == smc_pkg::COUNTER_MAX) ? col_reg : col_reg + 1'b1;
            end
            if (suppress_reg != '0)
            begin
                suppress_next = suppress_reg - 1'b1;
            end
            else if (raw_hit)
            begin
                suppress_next = len_m1;
            end
            if (end_of_file)
            begin
                row_next      = smc_pkg::COUNTER_BITS'(1);
                col_next      = smc_pkg::COUNTER_BITS'(1);
                suppress_next = '0;
                file_next     = file_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= smc_pkg::COUNTER_BITS'(1);
            col_reg      <= smc_pkg::COUNTER_BITS'(1);
            suppress_reg <= '0;
            file_reg     <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            suppress_reg <= suppress_next;
            file_reg     <= file_next;
        end
    end

    // Output register with a one-word skid buffer behind it.
    assign push = in_accept && hit;
    assign pop  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = new_result;
            end
            else
            begin
                out_valid_next = push;
                out_next       = new_result;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = new_result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = new_result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign file_number  = out_reg.file;
    assign match_row    = out_reg.row;
    assign match_column = out_reg.col;

`ifndef ASSERT_OFF
    // The skid word is only ever filled behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a word while the output is empty");

    // Reported positions are 1-based.
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (match_row != '0) && (match_column != '0))
        else $error("match reported at row or column zero");

    // A stalled result is never dropped.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled match word was lost");

    // A match inside a file skips the end positions that would overlap it.
    a_suppress_set: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !end_of_file) |=> (suppress_reg == $past(len_m1)))
        else $error("suppression count does not follow the matched length");
`endif

endmodule

// ----- bench/substring_match_row_column_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_match_row_column_tb: self-checking bench for the pattern search
// Streams the text of many short files through the block and checks each
// reported match (file, row, column) against a cycle-free scanner kept in
// the bench. A directed part covers the corner cases: reset settings,
// lengths zero and above eight, newlines, file boundaries and a pattern
// change inside a file. Random settings and text with embedded pattern
// copies follow, while both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module substring_match_row_column_tb;

    import smc_pkg::*;

    localparam int RANDOM_WORDS  = 1300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    // Receiver stall behaviors, switched at random by the monitor.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // One text word waiting for the input channel.
    typedef struct packed {
        logic [TEXT_W-1:0] data;
        logic              last;
    } text_word_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_write    = 1'b0;
    logic [0:0]              cfg_index    = CFG_PATTERN;
    logic [CFG_W-1:0]        cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic [TEXT_W-1:0]       text_byte    = '0;
    logic                    end_of_file  = 1'b0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic [FILE_W-1:0]       file_number;
    logic [COUNTER_BITS-1:0] match_row;
    logic [COUNTER_BITS-1:0] match_column;

    // Words still to be sent and matches still to be seen.
    text_word_t  pending_text[$];
    smc_result_t match_queue[$];

    // Scanner copy of the configuration and of the block's state.
    logic [PAT_W-1:0]        scan_pattern;
    logic [LEN_W-1:0]        scan_length;
    logic [TEXT_W-1:0]       win_byte [MAX_PATTERN];
    logic [COUNTER_BITS-1:0] win_row  [MAX_PATTERN];
    logic [COUNTER_BITS-1:0] win_col  [MAX_PATTERN];
    logic [COUNTER_BITS-1:0] next_row;
    logic [COUNTER_BITS-1:0] next_col;
    int unsigned             window_fill;
    int unsigned             skip_left;
    logic [FILE_W-1:0]       file_index;

    // Sender and receiver pacing.
    bit          hold_sender;
    int unsigned burst_left;
    int unsigned gap_left;
    text_word_t  next_word;
    stall_mode_t stall_mode;
    int unsigned stall_tick;

    // Run statistics.
    int unsigned error_count;
    int unsigned words_accepted;
    int unsigned matches_checked;
    int unsigned settings_used;
    int unsigned cycle_count;

    substring_match_row_column u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .file_number  (file_number),
        .match_row    (match_row),
        .match_column (match_column)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Length in use: zero reads as one, anything above eight as eight.
    function automatic int unsigned effective_length();
        if (scan_length == 0)
            return 1;
        if (scan_length > MAX_PATTERN)
            return MAX_PATTERN;
        return scan_length;
    endfunction

    // Advance the scanner by one text word and queue the match it completes.
    task automatic scan_byte(input logic [TEXT_W-1:0] data, input logic last);
        int unsigned len;
        bit          hit;
        smc_result_t found;
        len = effective_length();
        for (int i = MAX_PATTERN - 1; i > 0; i--)
        begin
            win_byte[i] = win_byte[i-1];
            win_row[i]  = win_row[i-1];
            win_col[i]  = win_col[i-1];
        end
        win_byte[0] = data;
        win_row[0]  = next_row;
        win_col[0]  = next_col;

        // A newline closes its own row; the next byte opens a new one.
        if (data == NEWLINE)
        begin
            next_row = (next_row == COUNTER_MAX) ? next_row : next_row + 1'b1;
            next_col = COUNTER_BITS'(1);
        end
        else
            next_col = (next_col == COUNTER_MAX) ? next_col : next_col + 1'b1;
        if (window_fill < MAX_PATTERN)
            window_fill++;

        // End positions inside the last match are skipped.
        if (skip_left > 0)
            skip_left--;
        else if (window_fill >= len)
        begin
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (win_byte[len-1-k] != scan_pattern[8*k +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                found.file = file_index;
                found.row  = win_row[len-1];
                found.col  = win_col[len-1];
                match_queue = {match_queue, found};
                skip_left = len - 1;
            end
        end

        if (last)
        begin
            next_row    = COUNTER_BITS'(1);
            next_col    = COUNTER_BITS'(1);
            window_fill = 0;
            skip_left   = 0;
            file_index++;
        end
    endtask

    task automatic report_error(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Compare one match from the block with the oldest one predicted.
    task automatic check_match();
        smc_result_t want;
        if (match_queue.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t ns: unexpected match: file %0d row %0d column %0d",
                         $time, file_number, match_row, match_column);
        end
        else
        begin
            want = match_queue.pop_front();
            matches_checked++;
            if (file_number !== want.file)
                report_error("file_number", want.file, file_number);
            if (match_row !== want.row)
                report_error("match_row", want.row, match_row);
            if (match_column !== want.col)
                report_error("match_column", want.col, match_column);
        end
    endtask

    // Driver: accepted words feed the scanner, then the next word is offered
    // in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            text_byte   <= '0;
            end_of_file <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                scan_byte(text_byte, end_of_file);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (hold_sender || pending_text.size() == 0 || gap_left > 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_word = pending_text.pop_front();
                    in_valid    <= 1'b1;
                    text_byte   <= next_word.data;
                    end_of_file <= next_word.last;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: checks accepted matches and stalls on a pattern of its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = STALL_NONE;
            stall_tick = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_match();
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
                STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout: %0d words unsent, %0d matches outstanding",
                     pending_text.size(), match_queue.size());
            $display("substring_match_row_column_tb: done, errors");
            $finish;
        end
    end

    // Register write through the configuration port; the block is idle.
    task automatic write_reg(input cfg_index_t index, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == CFG_PATTERN)
            scan_pattern = value;
        else
            scan_length = value[LEN_W-1:0];
        @(negedge clk);
    endtask

    task automatic add_word(input logic [TEXT_W-1:0] data, input logic last);
        text_word_t word;
        word.data = data;
        word.last = last;
        pending_text = {pending_text, word};
    endtask

    // Random text: copies of the pattern (some cut short), newlines,
    // pattern-like bytes and noise, with files ending at random.
    task automatic queue_text(input int unsigned count, output int unsigned made);
        int unsigned plen;
        int unsigned cut;
        logic [TEXT_W-1:0] data;
        plen = effective_length();
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, plen) : plen;
                    for (int k = 0; k < cut; k++)
                    begin
                        add_word(scan_pattern[8*k +: 8], $urandom_range(0, 24) == 0);
                        made++;
                    end
                end
                3:
                begin
                    add_word(NEWLINE, $urandom_range(0, 24) == 0);
                    made++;
                end
                4, 5:
                begin
                    add_word(TEXT_W'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
                    made++;
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        data = scan_pattern[8*$urandom_range(0, plen - 1) +: 8];
                    else
                        data = ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h62;
                    add_word(data, $urandom_range(0, 24) == 0);
                    made++;
                end
            endcase
        end
    endtask

    // Wait until every word is sent and every match has come, then let the
    // pipeline settle, since a last word may complete no match.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_text.size() != 0 || in_valid || match_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin : stimulus
        int unsigned      random_words;
        int unsigned      made;
        int unsigned      chunk;
        logic [LEN_W-1:0] len_value;
        logic [PAT_W-1:0] new_pattern;

        // Scanner reset state.
        scan_pattern = '0;
        scan_length  = LEN_W'(1);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_byte[i] = '0;
            win_row[i]  = '0;
            win_col[i]  = '0;
        end
        next_row     = COUNTER_BITS'(1);
        next_col     = COUNTER_BITS'(1);
        window_fill  = 0;
        skip_left    = 0;
        file_index   = '0;
        hold_sender  = 1'b0;
        random_words = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a single zero byte is the pattern.
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(NEWLINE, 1'b0);
        add_word(8'h00, 1'b1);
        wait_idle();
        settings_used++;

        // All-ones pattern with an oversized length, read as eight bytes;
        // the run of ten gives one match and suppresses the overlapping ones.
        write_reg(CFG_PATTERN, '1);
        write_reg(CFG_LENGTH, CFG_W'(4'hF));
        for (int i = 0; i < 10; i++)
            add_word(8'hFF, i == 9);
        wait_idle();
        settings_used++;

        // Length zero reads as one; newlines match at the ends of their rows.
        write_reg(CFG_PATTERN, CFG_W'(NEWLINE));
        write_reg(CFG_LENGTH, '0);
        add_word(NEWLINE, 1'b0);
        add_word(NEWLINE, 1'b0);
        add_word(8'h41, 1'b1);
        wait_idle();
        settings_used++;

        // A match may not span a file boundary.
        write_reg(CFG_PATTERN, CFG_W'(16'h6261));
        write_reg(CFG_LENGTH, CFG_W'(2));
        add_word(8'h61, 1'b1);
        add_word(8'h62, 1'b0);
        add_word(8'h61, 1'b0);
        add_word(8'h62, 1'b1);
        wait_idle();
        settings_used++;

        // Pattern changed in the middle of a file.
        write_reg(CFG_PATTERN, CFG_W'(8'h61));
        write_reg(CFG_LENGTH, CFG_W'(1));
        add_word(8'h78, 1'b0);
        add_word(8'h61, 1'b0);
        wait_idle();
        write_reg(CFG_PATTERN, CFG_W'(8'h78));
        add_word(8'h61, 1'b0);
        add_word(8'h78, 1'b1);
        wait_idle();
        settings_used += 2;

        // Random settings, each followed by a stretch of random text.
        while (random_words < RANDOM_WORDS)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                case ($urandom_range(0, 3))
                    0:       new_pattern[8*k +: 8] = 8'h61;
                    1:       new_pattern[8*k +: 8] = 8'h62;
                    2:       new_pattern[8*k +: 8] = NEWLINE;
                    default: new_pattern[8*k +: 8] = TEXT_W'($urandom_range(0, 255));
                endcase
            if (settings_used == 6)
                len_value = LEN_W'(1);
            else if (settings_used == 7)
                len_value = LEN_W'(MAX_PATTERN);
            else
                len_value = LEN_W'($urandom_range(0, 15));
            write_reg(CFG_PATTERN, new_pattern);
            write_reg(CFG_LENGTH, CFG_W'(len_value));
            settings_used++;

            chunk = $urandom_range(60, 160);
            if (settings_used == 9)
            begin
                // Sender holds off until every predicted match has come.
                queue_text(chunk / 2, made);
                random_words += made;
                do
                    @(negedge clk);
                while (pending_text.size() != 0);
                hold_sender = 1'b1;
                do
                    @(negedge clk);
                while (in_valid || match_queue.size() != 0);
                repeat (3) @(negedge clk);
                hold_sender = 1'b0;
                queue_text(chunk - chunk / 2, made);
            end
            else
                queue_text(chunk, made);
            random_words += made;
            wait_idle();
        end

        $display("covered %0d text words over %0d files and %0d pattern settings,",
                 words_accepted, file_index, settings_used);
        $display("with %0d matches checked against the scanner", matches_checked);
        if (error_count == 0)
            $display("substring_match_row_column_tb: done, clean");
        else
            $display("substring_match_row_column_tb: done, errors");
        $finish;
    end

endmodule
